FILE: sv/q24alu_pkg.sv
// Package for the Q24.8 fixed-point ALU: operation codes and the queued item type.
// No dependencies.
`default_nettype none
package q24alu_pkg;

   localparam int unsigned KIND_W = 4;
   localparam int unsigned DATA_W = 32;

   typedef enum logic [3:0] {
      OP_ADD      = 4'd0,
      OP_SUB      = 4'd1,
      OP_MUL      = 4'd2,
      OP_DIV      = 4'd3,
      OP_MIN      = 4'd4,
      OP_MAX      = 4'd5,
      OP_INC      = 4'd6,
      OP_DEC      = 4'd7,
      OP_FROM_INT = 4'd8,
      OP_TO_INT   = 4'd9,
      OP_NONE     = 4'd10
   } op_type;

   typedef struct packed {
      op_type             op;
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic               a_less;
      logic               a_equal;
      logic               a_greater;
   } item_type;

endpackage
`default_nettype wire

FILE: sv/q24alu_front.sv
// Front end of the ALU: decodes the opcode and compares the operands.
// Depends on q24alu_pkg.
`default_nettype none
module q24alu_front
   import q24alu_pkg::*;
(
   input  wire logic [KIND_W-1:0]        kind,
   input  wire logic signed [DATA_W-1:0] operand_a,
   input  wire logic signed [DATA_W-1:0] operand_b,
   output item_type                      item
);

   op_type op;

   always_comb begin
      unique case (kind)
         4'd0:    op = OP_ADD;
         4'd1:    op = OP_SUB;
         4'd2:    op = OP_MUL;
         4'd3:    op = OP_DIV;
         4'd4:    op = OP_MIN;
         4'd5:    op = OP_MAX;
         4'd6:    op = OP_INC;
         4'd7:    op = OP_DEC;
         4'd8:    op = OP_FROM_INT;
         4'd9:    op = OP_TO_INT;
         default: op = OP_NONE;
      endcase
   end

   always_comb begin
      item.op        = op;
      item.a         = operand_a;
      item.b         = operand_b;
      item.a_less    = (operand_a < operand_b);
      item.a_equal   = (operand_a == operand_b);
      item.a_greater = (operand_a > operand_b);
   end

endmodule
`default_nettype wire

FILE: sv/q24alu_queue.sv
// Two-entry queue between the front end and the execution pipeline.
// Depends on q24alu_pkg.
`default_nettype none
module q24alu_queue
   import q24alu_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  item_type  push_item,
   output logic      full,
   output logic      head_valid,
   output item_type  head_item
);

   item_type   mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign pop        = head_valid;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item = mem_ff[rd_ptr_ff];

endmodule
`default_nettype wire

FILE: sv/q24alu_back.sv
// Execution pipeline: simple ops, a 32x32 multiplier and a one-bit-per-stage divider.
// Depends on q24alu_pkg.
`default_nettype none
module q24alu_back
   import q24alu_pkg::*;
#(
   parameter int unsigned FRACTION_BITS = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  item_type               in_item,
   output logic                   out_valid,
   output logic signed [31:0]     out_value,
   output logic                   out_less,
   output logic                   out_equal,
   output logic                   out_greater,
   output logic                   out_overflow,
   output logic                   out_div_zero
);

   localparam int unsigned FB = FRACTION_BITS;
   localparam int unsigned NW = 34 + FB;
   localparam int unsigned DW = 34;
   localparam int unsigned MW = 65 - FB;
   localparam logic [31:0] SMAX = 32'h7FFF_FFFF;
   localparam logic [31:0] SMIN = 32'h8000_0000;

   typedef struct packed {
      op_type      op;
      logic        neg;
      logic        a_neg;
      logic [31:0] ma;
      logic [31:0] mb;
      logic [31:0] res;
      logic        ovf;
      logic        a_less;
      logic        a_equal;
      logic        a_greater;
   } exec_type;

   typedef struct packed {
      exec_type     ex;
      logic [63:0]  prod;
      logic [DW-1:0] rem;
      logic [NW-1:0] num;
      logic [NW-1:0] quo;
   } div_type;

   function automatic logic [32:0] sat33(input logic [32:0] x);
      logic [32:0] r;
      if (x[32] != x[31]) begin
         r = {1'b1, x[32] ? SMIN : SMAX};
      end else begin
         r = {1'b0, x[31:0]};
      end
      return r;
   endfunction

   logic signed [31:0] a, b;
   logic [32:0]        sum, diff, incr, decr, sel;
   logic [31+FB:0]     shl;
   logic [31:0]        mag_a, mag_b, trunc;
   exec_type           ex_in;
   exec_type           ex_ff;
   logic               ex_valid_ff;

   assign a     = in_item.a;
   assign b     = in_item.b;
   assign mag_a = a[31] ? (32'd0 - a) : a;
   assign mag_b = b[31] ? (32'd0 - b) : b;
   assign sum   = {a[31], a} + {b[31], b};
   assign diff  = {a[31], a} - {b[31], b};
   assign incr  = {a[31], a} + 33'd1;
   assign decr  = {a[31], a} - 33'd1;
   assign shl   = {{FB{a[31]}}, a} << FB;
   assign trunc = mag_a >> FB;

   always_comb begin
      sel = 33'd0;
      unique case (in_item.op)
         OP_ADD: sel = sat33(sum);
         OP_SUB: sel = sat33(diff);
         OP_MIN: sel = {1'b0, in_item.a_less ? a : b};
         OP_MAX: sel = {1'b0, in_item.a_greater ? a : b};
         OP_INC: sel = sat33(incr);
         OP_DEC: sel = sat33(decr);
         OP_FROM_INT: begin
            if (shl[31+FB:31] != {(FB+1){1'b0}} && shl[31+FB:31] != {(FB+1){1'b1}}) begin
               sel = {1'b1, a[31] ? SMIN : SMAX};
            end else begin
               sel = {1'b0, shl[31:0]};
            end
         end
         OP_TO_INT: sel = {1'b0, a[31] ? (32'd0 - trunc) : trunc};
         default: sel = 33'd0;
      endcase
   end

   always_comb begin
      ex_in.op        = in_item.op;
      ex_in.neg       = a[31] ^ b[31];
      ex_in.a_neg     = a[31];
      ex_in.ma        = mag_a;
      ex_in.mb        = mag_b;
      ex_in.res       = sel[31:0];
      ex_in.ovf       = sel[32];
      ex_in.a_less    = in_item.a_less;
      ex_in.a_equal   = in_item.a_equal;
      ex_in.a_greater = in_item.a_greater;
   end

   always_ff @(posedge clock) begin
      ex_ff <= ex_in;
   end

   div_type       st_ff [NW+1];
   logic [NW:0]   st_valid_ff;
   div_type       st0_in;
   logic [DW-1:0] dvs;

   always_comb begin
      st0_in.ex   = ex_ff;
      st0_in.prod = ex_ff.ma * ex_ff.mb;
      st0_in.rem  = {DW{1'b0}};
      st0_in.num  = ({2'b00, ex_ff.ma, {FB{1'b0}}} << 1) + {{(NW-32){1'b0}}, ex_ff.mb};
      st0_in.quo  = {NW{1'b0}};
   end

   always_ff @(posedge clock) begin
      st_ff[0] <= st0_in;
   end

   for (genvar i = 1; i <= NW; i++) begin : g_div
      logic [DW:0] trial;
      logic [DW:0] dsr;
      logic        take;
      div_type     nxt;
      always_comb begin
         dsr   = {2'b00, st_ff[i-1].ex.mb, 1'b0};
         trial = {st_ff[i-1].rem, st_ff[i-1].num[NW-1]};
         take  = (trial >= dsr);
         nxt   = st_ff[i-1];
         nxt.rem = take ? DW'(trial - dsr) : trial[DW-1:0];
         nxt.num = {st_ff[i-1].num[NW-2:0], 1'b0};
         nxt.quo = {st_ff[i-1].quo[NW-2:0], take};
      end
      always_ff @(posedge clock) begin
         st_ff[i] <= nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff <= 1'b0;
         st_valid_ff <= '0;
      end else begin
         ex_valid_ff <= in_valid;
         st_valid_ff <= {st_valid_ff[NW-1:0], ex_valid_ff};
      end
   end

   div_type       fin;
   logic [64:0]   rnd;
   logic [MW-1:0] mr;
   logic [31:0]   res_in;
   logic          ovf_in, dz_in;

   assign dvs = {1'b0, fin.ex.mb, 1'b0};
   assign fin = st_ff[NW];
   assign rnd = {1'b0, fin.prod} + (65'd1 << (FB - 1));
   assign mr  = rnd[64:FB];

   always_comb begin
      res_in = fin.ex.res;
      ovf_in = fin.ex.ovf;
      dz_in  = 1'b0;
      unique case (fin.ex.op)
         OP_MUL: begin
            if (mr > {{(MW-32){1'b0}}, fin.ex.neg ? SMIN : SMAX}) begin
               ovf_in = 1'b1;
               res_in = fin.ex.neg ? SMIN : SMAX;
            end else begin
               ovf_in = 1'b0;
               res_in = fin.ex.neg ? (32'd0 - mr[31:0]) : mr[31:0];
            end
         end
         OP_DIV: begin
            if (dvs == {DW{1'b0}}) begin
               dz_in  = 1'b1;
               ovf_in = 1'b0;
               res_in = fin.ex.a_neg ? SMIN : SMAX;
            end else if (fin.quo > {{(NW-32){1'b0}}, fin.ex.neg ? SMIN : SMAX}) begin
               ovf_in = 1'b1;
               res_in = fin.ex.neg ? SMIN : SMAX;
            end else begin
               ovf_in = 1'b0;
               res_in = fin.ex.neg ? (32'd0 - fin.quo[31:0]) : fin.quo[31:0];
            end
         end
         default: begin
            res_in = fin.ex.res;
            ovf_in = fin.ex.ovf;
         end
      endcase
   end

   logic out_valid_ff;
   logic [31:0] out_value_ff;
   logic out_less_ff, out_equal_ff, out_greater_ff, out_ovf_ff, out_dz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= st_valid_ff[NW];
      end
   end

   always_ff @(posedge clock) begin
      out_value_ff   <= res_in;
      out_less_ff    <= fin.ex.a_less;
      out_equal_ff   <= fin.ex.a_equal;
      out_greater_ff <= fin.ex.a_greater;
      out_ovf_ff     <= ovf_in;
      out_dz_ff      <= dz_in;
   end

   assign out_valid    = out_valid_ff;
   assign out_value    = out_value_ff;
   assign out_less     = out_less_ff;
   assign out_equal    = out_equal_ff;
   assign out_greater  = out_greater_ff;
   assign out_overflow = out_ovf_ff;
   assign out_div_zero = out_dz_ff;

endmodule
`default_nettype wire

FILE: sv/q24_8_fixed_point_alu.sv
// Top level of the signed Q24.8 fixed-point ALU.
// Depends on q24alu_pkg, q24alu_front, q24alu_queue and q24alu_back.
//
// Usage:
//   Drive req_kind, req_operand_a and req_operand_b with start high; the beat
//   is taken at a rising edge where busy is low. busy rises only when the
//   two-entry queue is full, which the pipeline never lets happen, so a new
//   beat can be taken every cycle.
//   Each beat yields one result beat: rsp_valid is high for one cycle with
//   the value and flags on the rsp_ ports. The receiver cannot stall; every
//   result must be taken in the cycle it is shown. Results leave in the
//   order the beats came in.
//   Every opcode passes through the same registers, so results of all opcodes
//   are equally delayed. The divider sets the pipeline depth: it retires one
//   quotient bit per pipeline stage over FRACTION_BITS + 34 stages.
//   Throughput: one beat per cycle.
//   Reset (synchronous, active high) empties the queue and drops every beat
//   in flight; no result appears for them.
`default_nettype none
module q24_8_fixed_point_alu
   import q24alu_pkg::*;
#(
   parameter int unsigned FRACTION_BITS = 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [3:0]          req_kind,
   input  wire logic signed [31:0]  req_operand_a,
   input  wire logic signed [31:0]  req_operand_b,
   output logic                     rsp_valid,
   output logic signed [31:0]       rsp_result_value,
   output logic                     rsp_a_less,
   output logic                     rsp_a_equal,
   output logic                     rsp_a_greater,
   output logic                     rsp_overflowed,
   output logic                     rsp_divided_by_zero
);

   item_type front_item;
   item_type head_item;
   logic     head_valid;
   logic     full;

   q24alu_front u_front (
      .kind      (req_kind),
      .operand_a (req_operand_a),
      .operand_b (req_operand_b),
      .item      (front_item)
   );

   assign busy = full;

   q24alu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (start & ~full),
      .push_item  (front_item),
      .full       (full),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   q24alu_back #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (head_valid),
      .in_item      (head_item),
      .out_valid    (rsp_valid),
      .out_value    (rsp_result_value),
      .out_less     (rsp_a_less),
      .out_equal    (rsp_a_equal),
      .out_greater  (rsp_a_greater),
      .out_overflow (rsp_overflowed),
      .out_div_zero (rsp_divided_by_zero)
   );

endmodule
`default_nettype wire

FILE: tb/sv/q24_8_fixed_point_alu_tb.sv
// Self-checking testbench for the Q24.8 fixed-point ALU: directed and random beats,
// results predicted in exact integer arithmetic and compared on every field.
// Depends on q24alu_pkg and q24_8_fixed_point_alu.
`timescale 1ns / 100ps
module q24_8_fixed_point_alu_tb;
   import q24alu_pkg::*;

   localparam int FRAC = 8;
   localparam int LATENCY = FRAC + 37;
   localparam longint S32_MAX = 64'sd2147483647;
   localparam longint S32_MIN = -64'sd2147483648;
   localparam int RANDOM_BEATS = 1750;
   localparam longint CYCLE_LIMIT = 200000;

   typedef struct {
      logic [3:0]         kind;
      logic signed [31:0] a;
      logic signed [31:0] b;
   } alu_beat;

   typedef struct {
      logic signed [31:0] value;
      logic               lt;
      logic               eq;
      logic               gt;
      logic               ovf;
      logic               dz;
   } alu_answer;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [3:0] req_kind = '0;
   logic signed [31:0] req_operand_a = '0;
   logic signed [31:0] req_operand_b = '0;
   logic rsp_valid;
   logic signed [31:0] rsp_result_value;
   logic rsp_a_less, rsp_a_equal, rsp_a_greater, rsp_overflowed, rsp_divided_by_zero;

   alu_beat   pending_beats[$];
   alu_answer expected_answers[$];
   int        send_idle_pct = 0;
   int        errors = 0;
   int        checked = 0;
   int        op_seen[16];
   longint    cycles = 0;

   q24_8_fixed_point_alu #(.FRACTION_BITS(FRAC)) dut (
      .clock, .reset, .start, .busy, .req_kind, .req_operand_a, .req_operand_b,
      .rsp_valid, .rsp_result_value, .rsp_a_less, .rsp_a_equal, .rsp_a_greater,
      .rsp_overflowed, .rsp_divided_by_zero
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic longint saturate(longint v, inout logic ovf);
      if (v > S32_MAX) begin
         ovf = 1'b1;
         return S32_MAX;
      end
      if (v < S32_MIN) begin
         ovf = 1'b1;
         return S32_MIN;
      end
      return v;
   endfunction

   function automatic alu_answer compute_alu(alu_beat t);
      alu_answer r;
      longint a, b, v, mag_a, mag_b, m;
      logic neg;
      a = t.a;
      b = t.b;
      r.ovf = 1'b0;
      r.dz = 1'b0;
      v = 0;
      neg = (a < 0) != (b < 0);
      mag_a = (a < 0) ? -a : a;
      mag_b = (b < 0) ? -b : b;
      case (t.kind)
         OP_ADD: v = saturate(a + b, r.ovf);
         OP_SUB: v = saturate(a - b, r.ovf);
         OP_MUL: begin
            m = longint'((64'(mag_a) * 64'(mag_b) + (64'd1 << (FRAC - 1))) >> FRAC);
            v = saturate(neg ? -m : m, r.ovf);
         end
         OP_DIV: begin
            if (b == 0) begin
               r.dz = 1'b1;
               v = (a < 0) ? S32_MIN : S32_MAX;
            end else begin
               m = (2 * (mag_a << FRAC) + mag_b) / (2 * mag_b);
               v = saturate(neg ? -m : m, r.ovf);
            end
         end
         OP_MIN: v = (a < b) ? a : b;
         OP_MAX: v = (a > b) ? a : b;
         OP_INC: v = saturate(a + 1, r.ovf);
         OP_DEC: v = saturate(a - 1, r.ovf);
         OP_FROM_INT: v = saturate(a * (64'sd1 <<< FRAC), r.ovf);
         OP_TO_INT: begin
            m = mag_a >> FRAC;
            v = (a < 0) ? -m : m;
         end
         default: v = 0;
      endcase
      r.value = v[31:0];
      r.lt = a < b;
      r.eq = a == b;
      r.gt = a > b;
      return r;
   endfunction

   function automatic logic [31:0] random_operand();
      case ($urandom_range(0, 9))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'($signed($urandom_range(0, 1024)) - 512);
         3: return $urandom_range(0, 1) ? 32'h00000000 : 32'h00000100;
         4: return 32'($signed($urandom_range(0, 65535)) - 32768);
         5: return 32'($signed($urandom_range(0, 16777215)) - 8388608);
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_beat(logic [3:0] kind, logic [31:0] a, logic [31:0] b);
      alu_beat t;
      t.kind = kind;
      t.a = a;
      t.b = b;
      pending_beats.push_back(t);
   endtask

   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         alu_beat t;
         t.kind = req_kind;
         t.a = req_operand_a;
         t.b = req_operand_b;
         expected_answers.push_back(compute_alu(t));
         op_seen[req_kind]++;
      end
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            alu_beat n;
            n = pending_beats.pop_front();
            start <= 1'b1;
            req_kind <= n.kind;
            req_operand_a <= n.a;
            req_operand_b <= n.b;
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_answers.size() == 0) begin
            $display("%0t: unexpected result value %h", $time, rsp_result_value);
            errors++;
         end else begin
            alu_answer e;
            e = expected_answers.pop_front();
            checked++;
            if ({rsp_result_value, rsp_a_less, rsp_a_equal, rsp_a_greater, rsp_overflowed,
                 rsp_divided_by_zero} !== {e.value, e.lt, e.eq, e.gt, e.ovf, e.dz}) begin
               $display("%0t: mismatch expected value %h lt%b eq%b gt%b ovf%b dz%b", $time,
                        e.value, e.lt, e.eq, e.gt, e.ovf, e.dz);
               $display("%0t:          actual   value %h lt%b eq%b gt%b ovf%b dz%b", $time,
                        rsp_result_value, rsp_a_less, rsp_a_equal, rsp_a_greater,
                        rsp_overflowed, rsp_divided_by_zero);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int phase, k, bit_i;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      // directed: every opcode at the extremes, divide by zero, rounding ties
      for (k = 0; k <= 10; k++) begin
         queue_beat(4'(k), 32'h7fffffff, 32'h80000000);
         queue_beat(4'(k), 32'h80000000, 32'h7fffffff);
      end
      queue_beat(OP_DIV, 32'h00000100, 32'h00000000);
      queue_beat(OP_DIV, 32'hffffff00, 32'h00000000);
      queue_beat(OP_MUL, 32'h00000001, 32'h00000080);
      queue_beat(OP_MUL, 32'hffffffff, 32'h00000080);
      queue_beat(4'd15, 32'h00000005, 32'h00000005);
      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 63 : 0;
         for (k = 0; k < RANDOM_BEATS / 3; k++) begin
            logic [31:0] a, b;
            a = random_operand();
            b = $urandom_range(0, 7) == 0 ? a : random_operand();
            queue_beat(4'($urandom_range(0, 12) > 10 ? $urandom_range(10, 15)
                          : $urandom_range(0, 9)), a, b);
         end
         // walk a single set bit through operand a and a single clear bit through operand b
         for (bit_i = 0; bit_i < 32; bit_i++)
            queue_beat(4'($urandom_range(0, 15)), 32'd1 << bit_i, ~(32'd1 << bit_i));
         wait (pending_beats.size() == 0);
      end
      @(posedge clock);
      while (start) @(posedge clock);
      while (expected_answers.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      $display("Checked %0d results; opcode counts add %0d mul %0d div %0d unused %0d",
               checked, op_seen[0], op_seen[2], op_seen[3], op_seen[15]);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule

FILE: sim.f
sv/q24alu_pkg.sv
sv/q24alu_front.sv
sv/q24alu_queue.sv
sv/q24alu_back.sv
sv/q24_8_fixed_point_alu.sv
tb/sv/q24_8_fixed_point_alu_tb.sv
